// ===== sv/tps_pkg.sv =====
// Package: sizes, codes and word types for the task phase sequencer.
`timescale 1ns / 1ps

package tps_pkg;

	// Table and timer sizes
	localparam int STATE_COUNT = 16;
	localparam int TIMER_BITS  = 32;
	localparam int IDX_W       = (STATE_COUNT > 1) ? $clog2(STATE_COUNT) : 1;
	localparam int TOUT_W      = 16;
	// Compare width that holds any 8-bit index and STATE_COUNT itself
	localparam int CMP_W       = 9;

	// Action codes
	localparam logic [3:0] ACT_RUN     = 4'd0;
	localparam logic [3:0] ACT_TICK    = 4'd1;
	localparam logic [3:0] ACT_SETNEXT = 4'd2;
	localparam logic [3:0] ACT_ADVANCE = 4'd3;
	localparam logic [3:0] ACT_RESTART = 4'd4;
	localparam logic [3:0] ACT_STOP    = 4'd5;
	localparam logic [3:0] ACT_END     = 4'd6;
	localparam logic [3:0] ACT_ATTACH  = 4'd7;
	localparam logic [3:0] ACT_DELETE  = 4'd8;

	// Hook codes
	localparam logic [1:0] HOOK_NONE  = 2'd0;
	localparam logic [1:0] HOOK_START = 2'd1;
	localparam logic [1:0] HOOK_RUN   = 2'd2;
	localparam logic [1:0] HOOK_END   = 2'd3;

	// Reset value of the timeout target register: no redirect
	localparam logic [4:0] TARGET_NONE = 5'd16;

	typedef enum logic [2:0] {
		PH_STANDBY   = 3'd0,
		PH_INIT      = 3'd1,
		PH_RUNNING   = 3'd2,
		PH_FINISHING = 3'd3,
		PH_FINISHED  = 3'd4
	} phase_t;

	typedef struct packed {
		logic [3:0]  action;
		logic [7:0]  target_index;
		logic [15:0] timeout_value;
	} in_word_t;

	typedef struct packed {
		logic [1:0] hook_fired;
		logic [3:0] current_index;
		logic [2:0] phase_now;
		logic       timed_out;
		logic       state_corrupt;
	} out_word_t;

endpackage

// ===== sv/tps_entry_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module tps_entry_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/task_phase_sequencer_core.sv =====
// Top level: task phase sequencer with per-state timeout table in RAM.
//
// Channel  Dir  Handshake            Word
// -------  ---  -------------------  ----------------------------
// in       in   in_valid/in_ready    tps_pkg::in_word_t  (action)
// out      out  out_valid/out_ready  tps_pkg::out_word_t (result)
// cfg      in   cfg_valid/cfg_ready  timeout_target, 5 bits
//
// On accept (S_IDLE) the entry RAM reads the timeout of the entry that a run
// step would make active; in S_EXEC the update is applied and the output
// register loaded. A stalled output holds S_EXEC.
// Valid marks live in flip-flops cleared by arst_n; no clearing pass.
// One word is in flight at a time, so RAM write and read never overlap.
`timescale 1ns / 1ps

module task_phase_sequencer_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tps_pkg::in_word_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tps_pkg::out_word_t  out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [4:0]          cfg_data
);

	localparam int IW = tps_pkg::IDX_W;
	localparam int CW = tps_pkg::CMP_W;
	localparam int TB = tps_pkg::TIMER_BITS;

	typedef enum logic {S_IDLE, S_EXEC} seq_state_t;

	seq_state_t               state_q;
	tps_pkg::in_word_t        item_q;
	tps_pkg::phase_t          phase_q;
	logic [IW-1:0]            active_q;
	logic [IW-1:0]            req_q;
	logic [TB-1:0]            elapsed_q;
	logic [4:0]               target_q;
	logic [tps_pkg::STATE_COUNT-1:0] valid_q;
	logic                     out_valid_q;
	tps_pkg::out_word_t       out_q;

	logic                     in_fire;
	logic                     fin;
	logic [IW-1:0]            chg_act;
	tps_pkg::phase_t          chg_ph;
	logic [tps_pkg::TOUT_W-1:0] lim_rd;

	tps_pkg::phase_t          ph_n;
	logic [IW-1:0]            act_n;
	logic [IW-1:0]            req_n;
	logic [TB-1:0]            el_n;
	logic [1:0]               hook_n;
	logic                     tout_n;
	logic                     corrupt_n;
	logic                     sn_en;
	logic [IW-1:0]            sn_idx;
	logic                     idx_ok;
	logic                     tgt_ok;
	logic [IW:0]              adv_sum;
	logic                     ram_we;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign fin       = (state_q == S_EXEC) && (!out_valid_q || out_ready);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Pending state change as a run step would apply it
	always_comb begin
		chg_act = active_q;
		chg_ph  = phase_q;
		if (req_q != active_q) begin
			if (phase_q == tps_pkg::PH_STANDBY || phase_q == tps_pkg::PH_FINISHED) begin
				chg_act = req_q;
				chg_ph  = tps_pkg::PH_INIT;
			end else if (phase_q == tps_pkg::PH_RUNNING) begin
				chg_ph = tps_pkg::PH_FINISHING;
			end
		end
	end

	// Range checks
	assign idx_ok  = CW'(item_q.target_index) < CW'(tps_pkg::STATE_COUNT);
	assign tgt_ok  = CW'(target_q) < CW'(tps_pkg::STATE_COUNT);
	assign adv_sum = {1'b0, active_q} + (IW+1)'(1);
	assign ram_we  = fin && (item_q.action == tps_pkg::ACT_ATTACH) && idx_ok;

	// Entry timeout table
	tps_entry_ram #(
		.DEPTH (tps_pkg::STATE_COUNT),
		.WIDTH (tps_pkg::TOUT_W),
		.AW    (IW)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (IW'(item_q.target_index)),
		.wdata (item_q.timeout_value),
		.re    (in_fire),
		.raddr (chg_act),
		.rdata (lim_rd)
	);

	// Item update
	always_comb begin
		ph_n      = phase_q;
		act_n     = active_q;
		req_n     = req_q;
		el_n      = elapsed_q;
		hook_n    = tps_pkg::HOOK_NONE;
		tout_n    = 1'b0;
		corrupt_n = 1'b0;
		sn_en     = 1'b0;
		sn_idx    = IW'(item_q.target_index);
		unique case (item_q.action)
			tps_pkg::ACT_RUN: begin
				act_n = chg_act;
				ph_n  = chg_ph;
				if (valid_q[chg_act]) begin
					unique case (chg_ph)
						tps_pkg::PH_INIT: begin
							hook_n = tps_pkg::HOOK_START;
							el_n   = '0;
							ph_n   = tps_pkg::PH_RUNNING;
						end
						tps_pkg::PH_RUNNING: begin
							hook_n = tps_pkg::HOOK_RUN;
							if (lim_rd != '0 && elapsed_q >= TB'(lim_rd)) begin
								tout_n = 1'b1;
								if (tgt_ok) begin
									sn_en  = 1'b1;
									sn_idx = IW'(target_q);
									el_n   = '0;
								end
							end
						end
						tps_pkg::PH_FINISHING: begin
							hook_n = tps_pkg::HOOK_END;
							ph_n   = tps_pkg::PH_FINISHED;
						end
						tps_pkg::PH_FINISHED: begin
							if (chg_act == req_q) begin
								ph_n = tps_pkg::PH_STANDBY;
							end
						end
						default: begin
						end
					endcase
				end else begin
					corrupt_n = 1'b1;
				end
			end
			tps_pkg::ACT_TICK: begin
				if (elapsed_q != '1) begin
					el_n = elapsed_q + TB'(1);
				end
			end
			tps_pkg::ACT_SETNEXT: begin
				sn_en = idx_ok;
			end
			tps_pkg::ACT_ADVANCE: begin
				sn_en  = adv_sum < (IW+1)'(tps_pkg::STATE_COUNT);
				sn_idx = adv_sum[IW-1:0];
			end
			tps_pkg::ACT_RESTART: ph_n = tps_pkg::PH_INIT;
			tps_pkg::ACT_STOP:    ph_n = tps_pkg::PH_STANDBY;
			tps_pkg::ACT_END:     ph_n = tps_pkg::PH_FINISHING;
			default: begin
			end
		endcase
		// Next-state request
		if (sn_en) begin
			req_n = sn_idx;
			if (sn_idx == act_n) begin
				if (ph_n == tps_pkg::PH_STANDBY) begin
					ph_n = tps_pkg::PH_INIT;
				end else if (ph_n == tps_pkg::PH_RUNNING) begin
					ph_n = tps_pkg::PH_FINISHING;
				end
			end
		end
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_q <= in_data;
		end
	end

	// Sequencer, state registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= tps_pkg::PH_STANDBY;
			active_q    <= '0;
			req_q       <= '0;
			elapsed_q   <= '0;
			target_q    <= tps_pkg::TARGET_NONE;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				target_q <= cfg_data;
			end
			// a new result reloads the output register in the same cycle
			if (out_valid_q && out_ready && !fin) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (fin) begin
						state_q   <= S_IDLE;
						phase_q   <= ph_n;
						active_q  <= act_n;
						req_q     <= req_n;
						elapsed_q <= el_n;
						if (idx_ok && item_q.action == tps_pkg::ACT_ATTACH) begin
							valid_q[IW'(item_q.target_index)] <= 1'b1;
						end
						if (idx_ok && item_q.action == tps_pkg::ACT_DELETE) begin
							valid_q[IW'(item_q.target_index)] <= 1'b0;
						end
						out_valid_q         <= 1'b1;
						out_q.hook_fired    <= hook_n;
						out_q.current_index <= 4'(act_n);
						out_q.phase_now     <= ph_n;
						out_q.timed_out     <= tout_n;
						out_q.state_corrupt <= corrupt_n;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Checks
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == S_EXEC))
		else $error("accepted word did not enter execute");

	a_corrupt_no_hook: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.state_corrupt) |->
		(out_q.hook_fired == tps_pkg::HOOK_NONE && !out_q.timed_out))
		else $error("invalid state reported together with a hook");

	a_timeout_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.timed_out) |-> (out_q.hook_fired == tps_pkg::HOOK_RUN))
		else $error("timeout reported outside a run hook");

	a_result_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_EXEC))
		else $error("result appeared without an executed word");

endmodule
